>>> rtl/plidl_pkg.sv
// ----------------------------------------------------------------------------
// Piecewise-linear distance lookup package
// Shared widths, reset table and the request types passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package plidl_pkg;

    localparam int TABLE_POINTS = 5;
    localparam int MV_W         = 13;
    localparam int DIST_W       = 10;
    localparam int POINT_W      = 26;
    localparam int DIST_LSB     = 16;
    localparam int SAMPLE_W     = 14;
    localparam int OUT_W        = 18;
    localparam int SEG_W        = 2;
    localparam int CNT_W        = 3;
    localparam int IDX_W        = 3;
    localparam int NUM_W        = MV_W + DIST_W + 8;
    localparam int QUO_W        = OUT_W;

    localparam logic [IDX_W-1:0] REG_POINT_COUNT = 3'd0;
    localparam logic [IDX_W-1:0] REG_POINT0      = 3'd1;

    localparam logic [CNT_W-1:0] POINT_COUNT_RESET = 3'd5;

    typedef logic [POINT_W-1:0] point_array_t [TABLE_POINTS];

    localparam point_array_t POINT_RESET = '{
        26'd3278300, 26'd2623440, 26'd1969080, 26'd1314720, 26'd659860
    };

    // One classified request waiting for the arithmetic back end.
    typedef struct packed {
        logic              in_range;
        logic [SEG_W-1:0]  segment;
        logic              zero_err;
        logic              calc;
        logic [MV_W-1:0]   dx;
        logic [DIST_W-1:0] dy_mag;
        logic              dy_neg;
        logic [DIST_W-1:0] y0;
        logic [MV_W-1:0]   den;
    } qent_t;

    // One request inside the divider pipeline.
    typedef struct packed {
        logic              in_range;
        logic [SEG_W-1:0]  segment;
        logic              zero_err;
        logic              calc;
        logic              dy_neg;
        logic [DIST_W-1:0] y0;
        logic [MV_W-1:0]   den;
        logic [MV_W:0]     rem;
        logic [QUO_W-1:0]  dvd;
    } div_t;

endpackage

`default_nettype wire

>>> rtl/plidl_front.sv
// ----------------------------------------------------------------------------
// Piecewise-linear distance lookup front end
// Accepts samples, checks the range and picks the segment and its operands.
// ----------------------------------------------------------------------------
`default_nettype none

module plidl_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           sample_valid,
    output logic                                sample_stall,
    input  wire logic [plidl_pkg::SAMPLE_W-1:0] sample_mv,
    input  wire logic [plidl_pkg::CNT_W-1:0]    point_count,
    input  wire plidl_pkg::point_array_t        points,
    output logic                                front_valid,
    output plidl_pkg::qent_t                    front_ent,
    input  wire logic                           queue_full
);
    import plidl_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    qent_t                 ent_reg;
    qent_t                 ent_next;
    logic                  accept;
    logic                  push;
    logic [CNT_W-1:0]      n_clamp;
    logic [MV_W-1:0]       xs [TABLE_POINTS];
    logic [DIST_W-1:0]     ys [TABLE_POINTS];
    logic [MV_W-1:0]       vm;
    logic [MV_W-1:0]       x_last;
    logic                  inr;
    logic                  found;
    logic [SEG_W-1:0]      sel;
    logic [MV_W-1:0]       x0;
    logic [MV_W-1:0]       x1;
    logic [DIST_W-1:0]     y0;
    logic [DIST_W-1:0]     y1;
    logic [DIST_W:0]       dy;

    assign push         = valid_reg && !queue_full;
    assign sample_stall = valid_reg && queue_full;
    assign accept       = sample_valid && !sample_stall;
    assign front_valid  = valid_reg;
    assign front_ent    = ent_reg;
    assign vm           = sample_mv[MV_W-1:0];

    always_comb
    begin
        if (point_count < CNT_W'(2))
            n_clamp = CNT_W'(2);
        else if (point_count > CNT_W'(TABLE_POINTS))
            n_clamp = CNT_W'(TABLE_POINTS);
        else
            n_clamp = point_count;
    end

    always_comb
    begin
        x_last = '0;
        for (int i = 0; i < TABLE_POINTS; i++)
        begin
            xs[i] = points[i][MV_W-1:0];
            ys[i] = points[i][DIST_LSB +: DIST_W];
            if (CNT_W'(i + 1) == n_clamp)
                x_last = xs[i];
        end
    end

    always_comb
    begin
        inr   = !sample_mv[SAMPLE_W-1] && (vm >= xs[0]) && (vm <= x_last);
        found = 1'b0;
        sel   = '0;
        // Walk downward so the lowest enclosing segment wins.
        for (int i = TABLE_POINTS - 2; i >= 0; i--)
        begin
            if ((CNT_W'(i + 1) < n_clamp) && (vm >= xs[i]) && (vm <= xs[i + 1]))
            begin
                found = 1'b1;
                sel   = SEG_W'(i);
            end
        end
        x0 = '0;
        x1 = '0;
        y0 = '0;
        y1 = '0;
        for (int i = 0; i < TABLE_POINTS - 1; i++)
        begin
            if (SEG_W'(i) == sel)
            begin
                x0 = xs[i];
                x1 = xs[i + 1];
                y0 = ys[i];
                y1 = ys[i + 1];
            end
        end
        dy = {1'b0, y1} - {1'b0, y0};

        ent_next.in_range = inr;
        ent_next.segment  = (inr && found) ? sel : '0;
        ent_next.zero_err = inr && found && (x1 == x0);
        ent_next.calc     = inr && found && (x1 != x0);
        ent_next.dx       = vm - x0;
        ent_next.dy_neg   = dy[DIST_W];
        ent_next.dy_mag   = dy[DIST_W] ? DIST_W'(-dy) : dy[DIST_W-1:0];
        ent_next.y0       = y0;
        ent_next.den      = x1 - x0;
    end

    assign valid_next = accept || (valid_reg && !push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            ent_reg <= ent_next;
    end

endmodule

`default_nettype wire

>>> rtl/plidl_queue.sv
// ----------------------------------------------------------------------------
// Piecewise-linear distance lookup request queue
// Four-entry queue that decouples the front end from the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module plidl_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire plidl_pkg::qent_t  push_ent,
    output logic                   full,
    input  wire logic              pop,
    output logic                   empty,
    output plidl_pkg::qent_t       head
);
    import plidl_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    qent_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (PTR_W + 1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_ent;
    end

endmodule

`default_nettype wire

>>> rtl/plidl_back.sv
// ----------------------------------------------------------------------------
// Piecewise-linear distance lookup back end
// Multiply stage, pipelined restoring divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module plidl_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         queue_empty,
    input  wire plidl_pkg::qent_t             head,
    output logic                              pop,
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output logic                              in_range,
    output logic [plidl_pkg::OUT_W-1:0]       distance_q8,
    output logic [plidl_pkg::SEG_W-1:0]       segment,
    output logic                              zero_width_error
);
    import plidl_pkg::*;

    localparam int STAGES = QUO_W;

    logic                        en;
    logic                        mul_valid_reg;
    qent_t                       mul_ent_reg;
    logic [NUM_W-1:0]            num_reg;
    logic [STAGES:0]             dv_reg;
    div_t                        dp_reg [STAGES+1];
    div_t                        dp_next [STAGES+1];
    logic                        out_valid_reg;
    logic                        out_inr_reg;
    logic [OUT_W-1:0]            out_dist_reg;
    logic [OUT_W-1:0]            out_dist_next;
    logic [SEG_W-1:0]            out_seg_reg;
    logic                        out_zerr_reg;
    logic [MV_W:0]               trial;
    logic [OUT_W:0]              base;
    logic [OUT_W:0]              sum;

    // The whole back end advances together whenever the result slot frees up.
    assign en  = !out_valid_reg || !result_stall;
    assign pop = en && !queue_empty;

    always_comb
    begin
        dp_next[0].in_range = mul_ent_reg.in_range;
        dp_next[0].segment  = mul_ent_reg.segment;
        dp_next[0].zero_err = mul_ent_reg.zero_err;
        dp_next[0].calc     = mul_ent_reg.calc;
        dp_next[0].dy_neg   = mul_ent_reg.dy_neg;
        dp_next[0].y0       = mul_ent_reg.y0;
        dp_next[0].den      = mul_ent_reg.den;
        // The quotient fits in QUO_W bits, so the upper bits are below the divisor.
        dp_next[0].rem      = {1'b0, num_reg[NUM_W-1 -: MV_W]};
        dp_next[0].dvd      = num_reg[QUO_W-1:0];
        trial               = '0;
        for (int k = 0; k < STAGES; k++)
        begin
            dp_next[k + 1] = dp_reg[k];
            trial = {dp_reg[k].rem[MV_W-1:0], dp_reg[k].dvd[QUO_W-1]};
            if (trial >= {1'b0, dp_reg[k].den})
            begin
                dp_next[k + 1].rem = trial - {1'b0, dp_reg[k].den};
                dp_next[k + 1].dvd = {dp_reg[k].dvd[QUO_W-2:0], 1'b1};
            end
            else
            begin
                dp_next[k + 1].rem = trial;
                dp_next[k + 1].dvd = {dp_reg[k].dvd[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        base = {1'b0, dp_reg[STAGES].y0, 8'd0};
        if (dp_reg[STAGES].dy_neg)
            sum = base - {1'b0, dp_reg[STAGES].dvd};
        else
            sum = base + {1'b0, dp_reg[STAGES].dvd};
        out_dist_next = dp_reg[STAGES].calc ? sum[OUT_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            dv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_valid_reg <= !queue_empty;
            dv_reg        <= {dv_reg[STAGES-1:0], mul_valid_reg};
            out_valid_reg <= dv_reg[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_ent_reg  <= head;
            num_reg      <= {(MV_W + DIST_W)'(head.dx * head.dy_mag), 8'd0};
            for (int k = 0; k <= STAGES; k++)
                dp_reg[k] <= dp_next[k];
            out_inr_reg  <= dp_reg[STAGES].in_range;
            out_dist_reg <= out_dist_next;
            out_seg_reg  <= dp_reg[STAGES].segment;
            out_zerr_reg <= dp_reg[STAGES].zero_err;
        end
    end

    assign result_valid     = out_valid_reg;
    assign in_range         = out_inr_reg;
    assign distance_q8      = out_dist_reg;
    assign segment          = out_seg_reg;
    assign zero_width_error = out_zerr_reg;

endmodule

`default_nettype wire

>>> rtl/piecewise_linear_distance_lookup_core.sv
// A request passes the front register, queue, multiply stage, divider and result register.
// Throughput: one request per cycle while result_stall is low, set by the fully pipelined 18-stage divider.
// The front end and the arithmetic back end are split by a four-entry queue.
// Reset clears all valid flags and loads the default five-point table.
// ----------------------------------------------------------------------------
// Piecewise-linear distance lookup core
// Top level: calibration registers, front end, queue and arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_distance_lookup_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [plidl_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [plidl_pkg::POINT_W-1:0]  cfg_data,
    input  wire logic                           sample_valid,
    output logic                                sample_stall,
    input  wire logic [plidl_pkg::SAMPLE_W-1:0] sample_mv,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic                                in_range,
    output logic [plidl_pkg::OUT_W-1:0]         distance_q8,
    output logic [plidl_pkg::SEG_W-1:0]         segment,
    output logic                                zero_width_error
);
    import plidl_pkg::*;

    logic [CNT_W-1:0] point_count_reg;
    point_array_t     points_reg;
    logic             front_valid;
    qent_t            front_ent;
    logic             queue_full;
    logic             queue_empty;
    logic             pop;
    qent_t            head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= POINT_COUNT_RESET;
            points_reg      <= POINT_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_POINT_COUNT)
                point_count_reg <= cfg_data[CNT_W-1:0];
            for (int i = 0; i < TABLE_POINTS; i++)
            begin
                if (cfg_index == REG_POINT0 + IDX_W'(i))
                    points_reg[i] <= cfg_data;
            end
        end
    end

    plidl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_mv    (sample_mv),
        .point_count  (point_count_reg),
        .points       (points_reg),
        .front_valid  (front_valid),
        .front_ent    (front_ent),
        .queue_full   (queue_full)
    );

    plidl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_valid),
        .push_ent (front_ent),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .head     (head)
    );

    plidl_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .queue_empty      (queue_empty),
        .head             (head),
        .pop              (pop),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .in_range         (in_range),
        .distance_q8      (distance_q8),
        .segment          (segment),
        .zero_width_error (zero_width_error)
    );

endmodule

`default_nettype wire

>>> rtl/plidl_checker.sv
// ----------------------------------------------------------------------------
// Piecewise-linear distance lookup checker
// Port-level properties of the lookup core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module plidl_props (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           result_valid,
    input  wire logic                           result_stall,
    input  wire logic                           in_range,
    input  wire logic [plidl_pkg::OUT_W-1:0]    distance_q8,
    input  wire logic [plidl_pkg::SEG_W-1:0]    segment,
    input  wire logic                           zero_width_error
);
    import plidl_pkg::*;

    // A request out of range carries no segment, distance or error.
    a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !in_range |->
            distance_q8 == '0 && segment == '0 && !zero_width_error)
        else $error("out-of-range result carries data");

    // A zero-width segment lies inside the range and yields no distance.
    a_zero_width: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && zero_width_error |-> in_range && distance_q8 == '0)
        else $error("zero-width result is inconsistent");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(distance_q8))
        else $error("stalled result changed");

endmodule

bind piecewise_linear_distance_lookup_core plidl_props u_plidl_props (
    .clk              (clk),
    .rst_n            (rst_n),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .in_range         (in_range),
    .distance_q8      (distance_q8),
    .segment          (segment),
    .zero_width_error (zero_width_error)
);

`default_nettype wire

>>> verif/plidl_checker.sv
// ----------------------------------------------------------------------------
// Distance lookup checker
// Watches the configuration port and both request channels. It keeps its own
// copy of the calibration table, predicts each result from the accepted
// sample, and compares the results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module plidl_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [plidl_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [plidl_pkg::POINT_W-1:0]  cfg_data,
    input  wire logic                           sample_valid,
    input  wire logic                           sample_stall,
    input  wire logic [plidl_pkg::SAMPLE_W-1:0] sample_mv,
    input  wire logic                           result_valid,
    input  wire logic                           result_stall,
    input  wire logic                           in_range,
    input  wire logic [plidl_pkg::OUT_W-1:0]    distance_q8,
    input  wire logic [plidl_pkg::SEG_W-1:0]    segment,
    input  wire logic                           zero_width_error,
    output int                                  mismatch_count,
    output int                                  outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    import plidl_pkg::*;

    typedef struct packed {
        logic             in_range;
        logic [OUT_W-1:0] distance_q8;
        logic [SEG_W-1:0] segment;
        logic             zero_width_error;
    } lookup_t;

    logic [CNT_W-1:0]   cal_count;
    logic [POINT_W-1:0] cal_points [TABLE_POINTS];
    lookup_t            expected_lookups [$];

    function automatic lookup_t interpolate(logic signed [SAMPLE_W-1:0] s);
        lookup_t r;
        int      n;
        int      v;
        int      x0;
        int      x1;
        int      y0;
        int      y1;
        longint  num;
        longint  d;
        bit      found;
        r     = '0;
        found = 0;
        n     = cal_count;
        if (n < 2) n = 2;
        if (n > TABLE_POINTS) n = TABLE_POINTS;
        v = s;
        if (!(v < int'(cal_points[0][MV_W-1:0]) || v > int'(cal_points[n-1][MV_W-1:0])))
        begin
            r.in_range = 1'b1;
            for (int i = 0; i + 1 < n; i++)
            begin
                x0 = cal_points[i][MV_W-1:0];
                x1 = cal_points[i+1][MV_W-1:0];
                if (!found && v >= x0 && v <= x1)
                begin
                    found     = 1;
                    r.segment = i[SEG_W-1:0];
                    if (x1 == x0)
                        r.zero_width_error = 1'b1;
                    else
                    begin
                        y0  = cal_points[i][DIST_LSB +: DIST_W];
                        y1  = cal_points[i+1][DIST_LSB +: DIST_W];
                        num = longint'(v - x0) * longint'(y1 - y0) * 256;
                        // Signed division truncates toward zero, as required.
                        d   = longint'(y0) * 256 + num / longint'(x1 - x0);
                        if (d < 0) d = 0;
                        r.distance_q8 = d[OUT_W-1:0];
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        lookup_t got;
        lookup_t exp_r;
        if (!rst_n)
        begin
            cal_count  <= POINT_COUNT_RESET;
            cal_points <= POINT_RESET;
            expected_lookups.delete();
            mismatch_count <= 0;
            outstanding    <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_POINT_COUNT)
                    cal_count <= cfg_data[CNT_W-1:0];
                else if (cfg_index - REG_POINT0 < TABLE_POINTS)
                    cal_points[cfg_index - REG_POINT0] <= cfg_data;
            end
            if (sample_valid && !sample_stall)
                expected_lookups.push_back(interpolate(sample_mv));
            if (result_valid && !result_stall)
            begin
                got = '{in_range, distance_q8, segment, zero_width_error};
                if (expected_lookups.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, got);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    exp_r = expected_lookups.pop_front();
                    if (got !== exp_r)
                    begin
                        $display("%0t: mismatch, expected %p, actual %p", $time, exp_r, got);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            outstanding <= expected_lookups.size();
        end
    end

endmodule

`default_nettype wire

>>> verif/tb_piecewise_linear_distance_lookup_core.sv
// ----------------------------------------------------------------------------
// Distance lookup core testbench
// Loads a series of calibration tables, among them overlapping, flat and
// descending ones, and sends directed and random voltages with random gaps
// and output stalls. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_piecewise_linear_distance_lookup_core;

    timeunit 1ns;
    timeprecision 1ps;

    import plidl_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [IDX_W-1:0]    cfg_index;
    logic [POINT_W-1:0]  cfg_data;
    logic                sample_valid;
    logic                sample_stall;
    logic [SAMPLE_W-1:0] sample_mv;
    logic                result_valid;
    logic                result_stall;
    logic                in_range;
    logic [OUT_W-1:0]    distance_q8;
    logic [SEG_W-1:0]    segment;
    logic                zero_width_error;
    int                  mismatch_count;
    int                  outstanding;

    // Sender and receiver idling, the long hold-off and the quiet tail.
    bit                  quiet;
    bit                  hold_request;
    int                  span_lo;
    int                  span_hi;
    logic [POINT_W-1:0]  table_points [TABLE_POINTS];

    piecewise_linear_distance_lookup_core i_dut (.*);

    plidl_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off on request.
    initial
    begin
        int  hold_cycles;
        int  burst;
        bit  held;
        held         = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !held)
            begin
                held        = 1;
                hold_cycles = 400;
                result_stall <= 1'b1;
                while (hold_cycles > 0)
                begin
                    @(posedge clk);
                    hold_cycles--;
                end
                result_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(1, 12);
                result_stall <= 1'b1;
                repeat (burst - 1) @(posedge clk);
                @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    task automatic send_sample(int v);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 12);
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_mv    <= v[SAMPLE_W-1:0];
        do @(posedge clk); while (sample_stall);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [POINT_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic drain;
        sample_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic logic [POINT_W-1:0] make_point(int x, int y);
        logic [POINT_W-1:0] p;
        p = '0;
        p[MV_W-1:0]              = x[MV_W-1:0];
        p[DIST_LSB-1:MV_W]       = (DIST_LSB - MV_W)'($urandom_range(0, 7));
        p[DIST_LSB +: DIST_W]    = y[DIST_W-1:0];
        return p;
    endfunction

    // shape: 0 rising, 1 rising with a flat segment, 2 unordered, 3 all max,
    // 4 all zero.
    task automatic load_table(int shape, int count);
        int x;
        int n;
        x = $urandom_range(0, 3000);
        for (int i = 0; i < TABLE_POINTS; i++)
        begin
            case (shape)
                0, 1:
                begin
                    if (i > 0) x = x + $urandom_range(1, 1400);
                    if (x > 8191) x = 8191;
                    if (shape == 1 && i == 2) x = int'(table_points[1][MV_W-1:0]);
                    table_points[i] = make_point(x, $urandom_range(0, 1023));
                end
                2: table_points[i] = make_point($urandom_range(0, 8191),
                                                $urandom_range(0, 1023));
                3: table_points[i] = 26'h3FFFFFF;
                default: table_points[i] = '0;
            endcase
            write_reg(IDX_W'(REG_POINT0 + i), table_points[i]);
        end
        write_reg(REG_POINT_COUNT, POINT_W'(count[CNT_W-1:0]));
        // Writes to indexes past the table must be dropped.
        write_reg(IDX_W'(REG_POINT0 + TABLE_POINTS), POINT_W'($urandom));
        write_reg(IDX_W'(REG_POINT0 + TABLE_POINTS + 1), POINT_W'($urandom));
        cfg_wr_en <= 1'b0;
        n = count < 2 ? 2 : (count > TABLE_POINTS ? TABLE_POINTS : count);
        span_lo = int'(table_points[0][MV_W-1:0]);
        span_hi = int'(table_points[n-1][MV_W-1:0]);
        if (span_hi < span_lo) span_hi = span_lo;
    endtask

    task automatic random_samples(int items);
        int v;
        for (int k = 0; k < items; k++)
        begin
            if ($urandom_range(0, 3) != 0)
                v = $urandom_range(span_lo > 20 ? span_lo - 20 : 0, span_hi + 20);
            else
            begin
                v = $urandom_range(0, 16383);
                if (v == 8192) v = 0;
                if (v > 8191) v = v - 16384;
            end
            if (v > 8191) v = 8191;
            send_sample(v);
        end
    endtask

    initial
    begin
        int directed [] = '{-8191, -1, 0, 1499, 1500, 1501, 1750, 2000, 2500,
                            3000, 3999, 4000, 4250, 4499, 4500, 4501, 8191};
        int counts [] = '{0, 1, 2, 3, 4, 5, 6, 7};
        quiet        = 0;
        hold_request = 0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        sample_valid = 1'b0;
        sample_mv    = '0;
        rst_n        = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default table straight out of reset.
        foreach (directed[i]) send_sample(directed[i]);
        drain();

        for (int ph = 0; ph < 14; ph++)
        begin
            case (ph)
                0: load_table(3, 5);
                1: load_table(4, 5);
                2, 3: load_table(1, counts[$urandom_range(3, 5)]);
                4: load_table(2, 5);
                5, 6: load_table(0, counts[ph]);
                default: load_table($urandom_range(0, 2), counts[ph % 8]);
            endcase
            // Samples right at every breakpoint, then random ones.
            for (int i = 0; i < TABLE_POINTS; i++)
                send_sample(int'(table_points[i][MV_W-1:0]));
            if (ph == 2) hold_request = 1;
            if (ph == 13) quiet = 1;
            random_samples(140);
            drain();
        end

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
